/* hw/rtl/tlc_pkg.sv */
`default_nettype none
package tlc_pkg;

  localparam int NEAR_SETS_D = 16;
  localparam int NEAR_WAYS_D = 4;
  localparam int FAR_SETS_D  = 64;
  localparam int FAR_WAYS_D  = 8;
  localparam int ADDR_BITS_D = 32;

  localparam int WAY_IDX_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int LAT_W      = 12;
  localparam int TOTAL_W    = 48;
  localparam int CNT_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET   = 3'd0,
    REG_L1_LAT   = 3'd1,
    REG_L2_LAT   = 3'd2,
    REG_MEM_LAT  = 3'd3,
    REG_WR_ALLOC = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic [WAY_IDX_W-1:0] vic_way;
  } set_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
    logic [CNT_W-1:0] r;
    r = c;
    if (en && (c != '1)) begin
      r = c + CNT_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tlc_if.sv */
`default_nettype none
interface tlc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] address;
  modport source (output valid, mode, address, input ready);
  modport sink (input valid, mode, address, output ready);
endinterface

interface tlc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          l1_miss;
  logic                          l2_accessed;
  logic                          l2_miss;
  logic [tlc_pkg::LAT_W-1:0]     access_latency;
  logic [tlc_pkg::TOTAL_W-1:0]   total_latency;
  logic [tlc_pkg::CNT_W-1:0]     access_count;
  logic [tlc_pkg::CNT_W-1:0]     l1_miss_count;
  logic [tlc_pkg::CNT_W-1:0]     l2_access_count;
  logic [tlc_pkg::CNT_W-1:0]     l2_miss_count;
  modport source (output valid, l1_miss, l2_accessed, l2_miss, access_latency, total_latency,
                  access_count, l1_miss_count, l2_access_count, l2_miss_count, input ready);
  modport sink (input valid, l1_miss, l2_accessed, l2_miss, access_latency, total_latency,
                access_count, l1_miss_count, l2_access_count, l2_miss_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tlc_tag_ram.sv */
`default_nettype none
module tlc_tag_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic      [WIDTH-1:0]                          q
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/tlc_set_unit.sv */
`default_nettype none
module tlc_set_unit #(
  parameter int WAYS  = 8,
  parameter int TAG_W = 32,
  parameter int AGE_W = 3
) (
  input  wire logic [WAYS-1:0]             way_en,
  input  wire logic [WAYS-1:0]             vld,
  input  wire logic [WAYS-1:0][TAG_W-1:0]  tags,
  input  wire logic [WAYS-1:0][AGE_W-1:0]  ages,
  input  wire logic [TAG_W-1:0]            key,
  input  wire logic                        use_victim,
  output tlc_pkg::set_res_t                res,
  output logic      [WAYS-1:0][AGE_W-1:0]  ages_out
);
  localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          hit;
  logic [WI-1:0] hw;
  logic          inv;
  logic [WI-1:0] iw;
  logic [WI-1:0] best;
  logic [WI-1:0] vic;
  logic [WI-1:0] tw;
  logic [AGE_W-1:0] a;

  always_comb begin
    hit  = 1'b0;
    hw   = '0;
    inv  = 1'b0;
    iw   = '0;
    best = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_en[w] && vld[w] && (tags[w] == key)) begin
        hit = 1'b1;
        hw  = WI'(w);
      end
      if (way_en[w] && !vld[w]) begin
        inv = 1'b1;
        iw  = WI'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (way_en[w] && (ages[w] > ages[best])) begin
        best = WI'(w);
      end
    end
    vic = inv ? iw : best;
    tw  = use_victim ? vic : hw;
    a   = ages[tw];
    for (int w = 0; w < WAYS; w++) begin
      ages_out[w] = (ages[w] < a) ? ages[w] + AGE_W'(1) : ages[w];
    end
    ages_out[tw] = '0;
    res.hit     = hit;
    res.hit_way = tlc_pkg::WAY_IDX_W'(hw);
    res.vic_way = tlc_pkg::WAY_IDX_W'(vic);
  end
endmodule
`default_nettype wire

/* hw/rtl/two_level_inclusive_lru_cache_model_core.sv */
`default_nettype none
// Channel   Direction  Payload
// in_ch     sink       mode, address
// out_ch    source     hit/miss flags, access latency, saturating statistics
// cfg_*     write      cfg_index selects one of five registers, cfg_data carries the value
//
// After reset a clearing pass over max(NEAR_SETS, FAR_SETS) rows initialises both tag stores.
// A first-level hit needs one lookup; a full miss adds a second lookup, back-invalidation,
// fill and writeback, each one read-modify-write of one set row through the shared set unit.
// The result waits in an output register; a new item is taken while it waits, but the final
// step stalls until the previous result is gone.
module two_level_inclusive_lru_cache_model_core #(
  parameter int NEAR_SETS = tlc_pkg::NEAR_SETS_D,
  parameter int NEAR_WAYS = tlc_pkg::NEAR_WAYS_D,
  parameter int FAR_SETS  = tlc_pkg::FAR_SETS_D,
  parameter int FAR_WAYS  = tlc_pkg::FAR_WAYS_D,
  parameter int ADDR_BITS = tlc_pkg::ADDR_BITS_D
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tlc_in_if.sink                               in_ch,
  tlc_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tlc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  localparam int NS_SH = $clog2(NEAR_SETS);
  localparam int FS_SH = $clog2(FAR_SETS);
  localparam int NS_W  = (NEAR_SETS > 1) ? NS_SH : 1;
  localparam int FS_W  = (FAR_SETS > 1) ? FS_SH : 1;
  localparam int MW    = (NEAR_WAYS > FAR_WAYS) ? NEAR_WAYS : FAR_WAYS;
  localparam int MI    = (MW > 1) ? $clog2(MW) : 1;
  localparam int AGE_W = (MW > 1) ? $clog2(MW) : 1;
  localparam int TAG_W = 32;
  localparam int LN_W  = 2 + TAG_W + AGE_W;
  localparam int NR_W  = NEAR_WAYS * LN_W;
  localparam int FR_W  = FAR_WAYS * LN_W;
  localparam int MAXS  = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
  localparam int CW    = (MAXS > 1) ? $clog2(MAXS) : 1;
  localparam logic [31:0] AMASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LN, S_LF, S_BI, S_NFR, S_NF, S_WB, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  off_r;
  logic [9:0]  l1_lat_r, l2_lat_r, mem_lat_r;
  logic        wa_r;

  logic [CW-1:0]  clr_cnt_r;
  logic [31:0]    blk_r;
  logic           wr_r;
  logic           l1m_r, l2m_r;
  logic [TAG_W-1:0] key_r;
  logic [NS_W-1:0] bi_set_r;
  logic [FS_W-1:0] wb_set_r;

  logic                          out_valid_r;
  logic                          o_l1m_r, o_l2m_r;
  logic [tlc_pkg::LAT_W-1:0]     o_lat_r;
  logic [tlc_pkg::TOTAL_W-1:0]   tot_r;
  logic [tlc_pkg::CNT_W-1:0]     acc_r, l1c_r, l2a_r, l2c_r;

  logic            near_we, near_re, far_we, far_re;
  logic [NS_W-1:0] near_waddr, near_raddr;
  logic [FS_W-1:0] far_waddr, far_raddr;
  logic [NR_W-1:0] near_wdata, near_q;
  logic [FR_W-1:0] far_wdata, far_q;

  logic [MW-1:0]             u_en, u_vld, u_dty;
  logic [MW-1:0][TAG_W-1:0]  u_tag;
  logic [MW-1:0][AGE_W-1:0]  u_age, u_age_out;
  logic [TAG_W-1:0]          u_key;
  logic                      u_use_vic;
  tlc_pkg::set_res_t         u_res;

  logic [MW-1:0]             m_vld, m_dty;
  logic [MW-1:0][TAG_W-1:0]  m_tag;
  logic [MW-1:0][AGE_W-1:0]  m_age;

  logic [31:0]     addr_m, blk_in;
  logic            lvl_far, fill, done_go, accept;
  logic [NS_W-1:0] nset;
  logic [FS_W-1:0] fset;
  logic [TAG_W-1:0] ntag, ftag, vtag, new_tag;
  logic            vvld, vdty;
  logic [MI-1:0]   vidx;
  logic [31:0]     ob_far, ob_near;
  logic            touch_en, set_line, set_dirty, clr_line, new_dirty;
  logic [MI-1:0]   mway;
  logic [tlc_pkg::LAT_W-1:0]     lat;
  logic [tlc_pkg::TOTAL_W:0]     tsum;

  tlc_tag_ram #(.DEPTH(NEAR_SETS), .WIDTH(NR_W)) u_near_ram (
    .clk(clk), .we(near_we), .waddr(near_waddr), .wdata(near_wdata),
    .re(near_re), .raddr(near_raddr), .q(near_q)
  );

  tlc_tag_ram #(.DEPTH(FAR_SETS), .WIDTH(FR_W)) u_far_ram (
    .clk(clk), .we(far_we), .waddr(far_waddr), .wdata(far_wdata),
    .re(far_re), .raddr(far_raddr), .q(far_q)
  );

  tlc_set_unit #(.WAYS(MW), .TAG_W(TAG_W), .AGE_W(AGE_W)) u_set (
    .way_en(u_en), .vld(u_vld), .tags(u_tag), .ages(u_age), .key(u_key),
    .use_victim(u_use_vic), .res(u_res), .ages_out(u_age_out)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign addr_m   = in_ch.address & AMASK;
  assign blk_in   = addr_m >> off_r;
  assign nset     = NS_W'(blk_r & 32'(NEAR_SETS - 1));
  assign fset     = FS_W'(blk_r & 32'(FAR_SETS - 1));
  assign ntag     = blk_r >> NS_SH;
  assign ftag     = blk_r >> FS_SH;
  assign fill     = !wr_r || wa_r;
  assign lvl_far  = (state_r == S_LF) || (state_r == S_WB);
  assign done_go  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    for (int w = 0; w < MW; w++) begin
      u_en[w]  = 1'b0;
      u_vld[w] = 1'b1;
      u_dty[w] = 1'b0;
      u_tag[w] = '0;
      u_age[w] = '0;
      if (lvl_far && (w < FAR_WAYS)) begin
        u_en[w] = 1'b1;
        {u_vld[w], u_dty[w], u_tag[w], u_age[w]} = far_q[(w % FAR_WAYS) * LN_W +: LN_W];
      end else if (!lvl_far && (w < NEAR_WAYS)) begin
        u_en[w] = 1'b1;
        {u_vld[w], u_dty[w], u_tag[w], u_age[w]} = near_q[(w % NEAR_WAYS) * LN_W +: LN_W];
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_LN:    u_key = ntag;
      S_LF:    u_key = ftag;
      default: u_key = key_r;
    endcase
    u_use_vic = (state_r == S_NF) || ((state_r == S_LF) && !u_res.hit);
    vidx      = u_res.vic_way[MI-1:0];
    vtag      = u_tag[vidx];
    vvld      = u_vld[vidx];
    vdty      = u_dty[vidx];
    ob_far    = (vtag << FS_SH) | 32'(fset);
    ob_near   = (vtag << NS_SH) | 32'(nset);
  end

  always_comb begin
    touch_en  = 1'b0;
    set_line  = 1'b0;
    set_dirty = 1'b0;
    clr_line  = 1'b0;
    new_dirty = wr_r;
    new_tag   = lvl_far ? ftag : ntag;
    unique case (state_r)
      S_LN: begin
        touch_en  = 1'b1;
        set_dirty = wr_r;
      end
      S_LF: begin
        touch_en  = 1'b1;
        set_dirty = u_res.hit && wr_r;
        set_line  = !u_res.hit;
      end
      S_BI: begin
        clr_line = 1'b1;
      end
      S_NF: begin
        touch_en = 1'b1;
        set_line = 1'b1;
      end
      S_WB: begin
        touch_en  = 1'b1;
        set_dirty = 1'b1;
      end
      default: begin
        touch_en = 1'b0;
      end
    endcase
    mway  = u_use_vic ? vidx : u_res.hit_way[MI-1:0];
    m_vld = u_vld;
    m_dty = u_dty;
    m_tag = u_tag;
    m_age = touch_en ? u_age_out : u_age;
    if (set_dirty) begin
      m_dty[mway] = 1'b1;
    end
    if (set_line) begin
      m_vld[mway] = 1'b1;
      m_dty[mway] = new_dirty;
      m_tag[mway] = new_tag;
    end
    if (clr_line) begin
      m_vld[mway] = 1'b0;
      m_dty[mway] = 1'b0;
    end
  end

  always_comb begin
    near_we    = 1'b0;
    far_we     = 1'b0;
    near_re    = 1'b0;
    far_re     = 1'b0;
    near_waddr = nset;
    far_waddr  = fset;
    near_raddr = nset;
    far_raddr  = fset;
    state_nxt  = state_r;
    for (int w = 0; w < NEAR_WAYS; w++) begin
      near_wdata[w * LN_W +: LN_W] = {m_vld[w], m_dty[w], m_tag[w], m_age[w]};
    end
    for (int w = 0; w < FAR_WAYS; w++) begin
      far_wdata[w * LN_W +: LN_W] = {m_vld[w], m_dty[w], m_tag[w], m_age[w]};
    end
    unique case (state_r)
      S_CLR: begin
        for (int w = 0; w < NEAR_WAYS; w++) begin
          near_wdata[w * LN_W +: LN_W] = {2'b00, TAG_W'(0), AGE_W'(w)};
        end
        for (int w = 0; w < FAR_WAYS; w++) begin
          far_wdata[w * LN_W +: LN_W] = {2'b00, TAG_W'(0), AGE_W'(w)};
        end
        near_we    = (32'(clr_cnt_r) < 32'(NEAR_SETS));
        far_we     = (32'(clr_cnt_r) < 32'(FAR_SETS));
        near_waddr = NS_W'(clr_cnt_r);
        far_waddr  = FS_W'(clr_cnt_r);
        if (32'(clr_cnt_r) == 32'(MAXS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        near_re    = accept;
        far_re     = accept;
        near_raddr = NS_W'(blk_in & 32'(NEAR_SETS - 1));
        far_raddr  = FS_W'(blk_in & 32'(FAR_SETS - 1));
        if (accept) begin
          state_nxt = S_LN;
        end
      end
      S_LN: begin
        near_we   = u_res.hit;
        state_nxt = u_res.hit ? S_DONE : S_LF;
      end
      S_LF: begin
        if (u_res.hit) begin
          far_we    = 1'b1;
          state_nxt = fill ? S_NFR : S_DONE;
        end else if (fill) begin
          far_we     = 1'b1;
          near_re    = vvld;
          near_raddr = NS_W'(ob_far & 32'(NEAR_SETS - 1));
          state_nxt  = vvld ? S_BI : S_NFR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BI: begin
        near_we    = u_res.hit;
        near_waddr = bi_set_r;
        state_nxt  = S_NFR;
      end
      S_NFR: begin
        near_re   = 1'b1;
        state_nxt = S_NF;
      end
      S_NF: begin
        near_we   = 1'b1;
        far_re    = vvld && vdty;
        far_raddr = FS_W'(ob_near & 32'(FAR_SETS - 1));
        state_nxt = (vvld && vdty) ? S_WB : S_DONE;
      end
      S_WB: begin
        far_we    = u_res.hit;
        far_waddr = wb_set_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign lat  = tlc_pkg::LAT_W'(l1_lat_r) + (l1m_r ? tlc_pkg::LAT_W'(l2_lat_r) : '0)
              + (l2m_r ? tlc_pkg::LAT_W'(mem_lat_r) : '0);
  assign tsum = {1'b0, tot_r} + (tlc_pkg::TOTAL_W + 1)'(lat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      off_r       <= 4'd4;
      l1_lat_r    <= 10'd1;
      l2_lat_r    <= 10'd5;
      mem_lat_r   <= 10'd100;
      wa_r        <= 1'b1;
      out_valid_r <= 1'b0;
      tot_r       <= '0;
      acc_r       <= '0;
      l1c_r       <= '0;
      l2a_r       <= '0;
      l2c_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          tlc_pkg::REG_OFFSET:   off_r     <= cfg_data[3:0];
          tlc_pkg::REG_L1_LAT:   l1_lat_r  <= cfg_data;
          tlc_pkg::REG_L2_LAT:   l2_lat_r  <= cfg_data;
          tlc_pkg::REG_MEM_LAT:  mem_lat_r <= cfg_data;
          tlc_pkg::REG_WR_ALLOC: wa_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
        tot_r <= tsum[tlc_pkg::TOTAL_W] ? '1 : tsum[tlc_pkg::TOTAL_W-1:0];
        acc_r <= tlc_pkg::sat_inc(acc_r, 1'b1);
        l1c_r <= tlc_pkg::sat_inc(l1c_r, l1m_r);
        l2a_r <= tlc_pkg::sat_inc(l2a_r, l1m_r);
        l2c_r <= tlc_pkg::sat_inc(l2c_r, l2m_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= blk_in;
      wr_r  <= in_ch.mode;
      l1m_r <= 1'b0;
      l2m_r <= 1'b0;
    end
    if (state_r == S_LN) begin
      l1m_r <= !u_res.hit;
    end
    if (state_r == S_LF) begin
      l2m_r    <= !u_res.hit;
      key_r    <= ob_far >> NS_SH;
      bi_set_r <= NS_W'(ob_far & 32'(NEAR_SETS - 1));
    end
    if (state_r == S_NF) begin
      key_r    <= ob_near >> FS_SH;
      wb_set_r <= FS_W'(ob_near & 32'(FAR_SETS - 1));
    end
    if (done_go) begin
      o_l1m_r <= l1m_r;
      o_l2m_r <= l2m_r;
      o_lat_r <= lat;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.l1_miss         = o_l1m_r;
  assign out_ch.l2_accessed     = o_l1m_r;
  assign out_ch.l2_miss         = o_l2m_r;
  assign out_ch.access_latency  = o_lat_r;
  assign out_ch.total_latency   = tot_r;
  assign out_ch.access_count    = acc_r;
  assign out_ch.l1_miss_count   = l1c_r;
  assign out_ch.l2_access_count = l2a_r;
  assign out_ch.l2_miss_count   = l2c_r;

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished item");

  a_l2_needs_l1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_l2m_r || o_l1m_r))
    else $error("second level miss reported on a first level hit");

  a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (l2c_r <= l2a_r) && (l1c_r <= acc_r))
    else $error("miss statistics exceed lookup statistics");

  a_no_clear_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ch.ready)
    else $error("input taken during the clearing pass");

endmodule
`default_nettype wire

/* dv/tlc_tb_if.sv */
`timescale 1ns / 100ps
// The block's own interfaces (tlc_in_if, tlc_out_if) carry both channels.
// The testbench instantiates them directly, so this file only holds a small
// record type shared by the testbench.
package tlc_tb_pkg;
  typedef struct packed {
    logic        l1_miss;
    logic        l2_accessed;
    logic        l2_miss;
    logic [11:0] access_latency;
    logic [47:0] total_latency;
    logic [31:0] access_count;
    logic [31:0] l1_miss_count;
    logic [31:0] l2_access_count;
    logic [31:0] l2_miss_count;
  } access_report_t;
endpackage

/* dv/two_level_inclusive_lru_cache_model_core_tb.sv */
`timescale 1ns / 100ps
module two_level_inclusive_lru_cache_model_core_tb;

  localparam int NSETS = 16;
  localparam int NWAYS = 4;
  localparam int FSETS = 64;
  localparam int FWAYS = 8;
  localparam longint MAX48 = (64'd1 << 48) - 1;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  tlc_pkg::cfg_reg_t cfg_index;
  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data;

  tlc_in_if in_ch();
  tlc_out_if out_ch();

  two_level_inclusive_lru_cache_model_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mirror of the cache state.
  logic [31:0] near_tag [NSETS][NWAYS];
  logic near_vld [NSETS][NWAYS];
  logic near_drt [NSETS][NWAYS];
  logic [3:0] near_rank [NSETS][NWAYS];
  logic [31:0] far_tag [FSETS][FWAYS];
  logic far_vld [FSETS][FWAYS];
  logic far_drt [FSETS][FWAYS];
  logic [3:0] far_rank [FSETS][FWAYS];
  logic [47:0] cyc_sum;
  logic [31:0] acc_n, nmiss_n, flook_n, fmiss_n;
  logic [3:0] offset_bits;
  logic [9:0] lat1, lat2, latm;
  logic alloc_on_write;

  tlc_tb_pkg::access_report_t expected_reports[$];
  int mismatches;
  longint cycles;
  logic stall_rx;

  function automatic int near_find(int s, logic [31:0] t);
    for (int w = 0; w < NWAYS; w++) begin
      if (near_vld[s][w] && near_tag[s][w] == t) return w;
    end
    return -1;
  endfunction

  function automatic int far_find(int s, logic [31:0] t);
    for (int w = 0; w < FWAYS; w++) begin
      if (far_vld[s][w] && far_tag[s][w] == t) return w;
    end
    return -1;
  endfunction

  function automatic void near_touch(int s, int w);
    logic [3:0] a;
    a = near_rank[s][w];
    for (int i = 0; i < NWAYS; i++) begin
      if (near_rank[s][i] < a) near_rank[s][i]++;
    end
    near_rank[s][w] = 0;
  endfunction

  function automatic void far_touch(int s, int w);
    logic [3:0] a;
    a = far_rank[s][w];
    for (int i = 0; i < FWAYS; i++) begin
      if (far_rank[s][i] < a) far_rank[s][i]++;
    end
    far_rank[s][w] = 0;
  endfunction

  function automatic void near_fill(logic [31:0] blk, logic wr);
    int s, v, fs, fw;
    logic [31:0] ob;
    s = blk % NSETS;
    v = -1;
    for (int w = 0; w < NWAYS; w++) begin
      if (v < 0 && !near_vld[s][w]) v = w;
    end
    if (v < 0) begin
      v = 0;
      for (int w = 1; w < NWAYS; w++) begin
        if (near_rank[s][w] > near_rank[s][v]) v = w;
      end
    end
    if (near_vld[s][v] && near_drt[s][v]) begin
      ob = near_tag[s][v] * NSETS + s;
      fs = ob % FSETS;
      fw = far_find(fs, ob / FSETS);
      if (fw >= 0) begin
        far_drt[fs][fw] = 1'b1;
        far_touch(fs, fw);
      end
    end
    near_tag[s][v] = blk / NSETS;
    near_vld[s][v] = 1'b1;
    near_drt[s][v] = wr;
    near_touch(s, v);
  endfunction

  function automatic void far_fill(logic [31:0] blk, logic wr);
    int s, v, ns, nw;
    logic [31:0] ob;
    s = blk % FSETS;
    v = -1;
    for (int w = 0; w < FWAYS; w++) begin
      if (v < 0 && !far_vld[s][w]) v = w;
    end
    if (v < 0) begin
      v = 0;
      for (int w = 1; w < FWAYS; w++) begin
        if (far_rank[s][w] > far_rank[s][v]) v = w;
      end
    end
    if (far_vld[s][v]) begin
      ob = far_tag[s][v] * FSETS + s;
      ns = ob % NSETS;
      nw = near_find(ns, ob / NSETS);
      if (nw >= 0) begin
        near_vld[ns][nw] = 1'b0;
        near_drt[ns][nw] = 1'b0;
      end
    end
    far_tag[s][v] = blk / FSETS;
    far_vld[s][v] = 1'b1;
    far_drt[s][v] = wr;
    far_touch(s, v);
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == '1) ? c : c + 1;
  endfunction

  function automatic void cache_clear();
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        near_vld[s][w] = 0; near_drt[s][w] = 0; near_tag[s][w] = 0; near_rank[s][w] = 4'(w);
      end
    end
    for (int s = 0; s < FSETS; s++) begin
      for (int w = 0; w < FWAYS; w++) begin
        far_vld[s][w] = 0; far_drt[s][w] = 0; far_tag[s][w] = 0; far_rank[s][w] = 4'(w);
      end
    end
    cyc_sum = 0; acc_n = 0; nmiss_n = 0; flook_n = 0; fmiss_n = 0;
    offset_bits = 4; lat1 = 1; lat2 = 5; latm = 100; alloc_on_write = 1;
  endfunction

  function automatic tlc_tb_pkg::access_report_t cache_access(logic wr, logic [31:0] addr);
    tlc_tb_pkg::access_report_t r;
    logic [31:0] blk;
    logic [11:0] lat;
    int ns, fs, nw, fw;
    r = '0;
    blk = addr >> offset_bits;
    ns = blk % NSETS;
    fs = blk % FSETS;
    lat = 12'(lat1);
    acc_n = bump(acc_n);
    nw = near_find(ns, blk / NSETS);
    if (nw >= 0) begin
      near_touch(ns, nw);
      if (wr) near_drt[ns][nw] = 1'b1;
    end else begin
      fw = far_find(fs, blk / FSETS);
      r.l1_miss = 1; r.l2_accessed = 1;
      lat += 12'(lat2);
      nmiss_n = bump(nmiss_n);
      flook_n = bump(flook_n);
      if (fw >= 0) begin
        far_touch(fs, fw);
        if (wr) far_drt[fs][fw] = 1'b1;
        if (!wr || alloc_on_write) near_fill(blk, wr);
      end else begin
        r.l2_miss = 1;
        lat += 12'(latm);
        fmiss_n = bump(fmiss_n);
        if (!wr || alloc_on_write) begin
          far_fill(blk, wr);
          near_fill(blk, wr);
        end
      end
    end
    if (MAX48 - cyc_sum < lat) cyc_sum = MAX48;
    else cyc_sum = cyc_sum + lat;
    r.access_latency = lat;
    r.total_latency = cyc_sum;
    r.access_count = acc_n;
    r.l1_miss_count = nmiss_n;
    r.l2_access_count = flook_n;
    r.l2_miss_count = fmiss_n;
    return r;
  endfunction

  function automatic void note_expected(tlc_tb_pkg::access_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  // The valid line stays high after an accepted item; pauses lower it.
  task automatic send_access(logic wr, logic [31:0] addr);
    in_ch.valid <= 1'b1;
    in_ch.mode <= wr;
    in_ch.address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    note_expected(cache_access(wr, addr));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(tlc_pkg::cfg_reg_t idx, logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tlc_pkg::REG_OFFSET: offset_bits = val[3:0];
      tlc_pkg::REG_L1_LAT: lat1 = val;
      tlc_pkg::REG_L2_LAT: lat2 = val;
      tlc_pkg::REG_MEM_LAT: latm = val;
      tlc_pkg::REG_WR_ALLOC: alloc_on_write = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic burst_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  logic [31:0] last_block_addr;

  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    case ($urandom_range(0, 9))
      0, 1: a = $urandom;
      2, 3, 4: a = last_block_addr ^ ($urandom_range(0, 15) << offset_bits);
      default: a = ($urandom_range(0, 31) * 16 * 64 + $urandom_range(0, 63)) << offset_bits
               | ($urandom & ((32'd1 << offset_bits) - 1));
    endcase
    last_block_addr = a;
    return a;
  endfunction

  task automatic test_directed();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0004);
    send_access(1'b1, 32'h0000_0008);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFF0);
    for (int i = 1; i <= 9; i++) send_access(1'b1, i * 32'h100);
    for (int i = 1; i <= 9; i++) send_access(1'b0, i * 32'h4000);
    send_access(1'b0, 32'h0000_0100);
    drain();
  endtask

  task automatic test_no_allocate();
    write_reg(tlc_pkg::REG_WR_ALLOC, 10'd0);
    send_access(1'b1, 32'h1234_5670);
    send_access(1'b1, 32'h1234_5670);
    send_access(1'b0, 32'h1234_5670);
    send_access(1'b1, 32'h1234_5670);
    drain();
    write_reg(tlc_pkg::REG_WR_ALLOC, 10'd1);
  endtask

  task automatic test_random_phase(int n, logic [3:0] ob, logic [9:0] a, logic [9:0] b,
                                   logic [9:0] c, logic wa);
    write_reg(tlc_pkg::REG_OFFSET, {6'd0, ob});
    write_reg(tlc_pkg::REG_L1_LAT, a);
    write_reg(tlc_pkg::REG_L2_LAT, b);
    write_reg(tlc_pkg::REG_MEM_LAT, c);
    write_reg(tlc_pkg::REG_WR_ALLOC, {9'd0, wa});
    for (int i = 0; i < n; i++) begin
      send_access(1'($urandom_range(0, 1)), pick_address());
      burst_gap();
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_rx ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          tlc_tb_pkg::access_report_t e, g;
          e = expected_reports.pop_front();
          g = {out_ch.l1_miss, out_ch.l2_accessed, out_ch.l2_miss, out_ch.access_latency,
               out_ch.total_latency, out_ch.access_count, out_ch.l1_miss_count,
               out_ch.l2_access_count, out_ch.l2_miss_count};
          if (g !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h got %h", e, g);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    stall_rx <= (cycles % 500) > 400;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_level_inclusive_lru_cache_model_core test failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    stall_rx = 0;
    last_block_addr = 0;
    cfg_we = 0;
    cfg_index = tlc_pkg::REG_OFFSET;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.address = 0;
    out_ch.ready = 0;
    rst_n = 0;
    cache_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_no_allocate();
    test_random_phase(500, 4'd4, 10'd1, 10'd5, 10'd100, 1'b1);
    test_random_phase(300, 4'd0, 10'd1023, 10'd1023, 10'd1023, 1'b0);
    test_random_phase(300, 4'd12, 10'd0, 10'd0, 10'd0, 1'b1);
    test_random_phase(250, 4'd15, 10'd7, 10'd300, 10'd513, 1'b1);
    test_random_phase(500, 4'd2, 10'd682, 10'd341, 10'd0, 1'b0);
    drain();
    if (mismatches == 0) begin
      $display("two_level_inclusive_lru_cache_model_core test passed");
    end else begin
      $display("two_level_inclusive_lru_cache_model_core test failed");
    end
    $finish;
  end
endmodule
